// ----- hdl/woi_pkg.sv -----
// Shared types, constants and tables for the wheel odometry integrator.
// Used by the multiplier, divider, rotator and top level; no dependencies.
`default_nettype none

package woi_pkg;

   // payload widths
   localparam int TS_W     = 32;
   localparam int STEER_W  = 16;
   localparam int TOTAL_W  = 32;
   localparam int POSE_W   = 32;
   localparam int REQ_W    = TS_W + STEER_W + 4 * TOTAL_W;
   localparam int RSP_W    = 5 * POSE_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // shared serial multiplier: signed a times signed b, b walked one bit a cycle
   localparam int MUL_A_W   = 65;
   localparam int MUL_B_W   = 42;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   // shared restoring divider, unsigned
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // rotator (sin/cos), Q2.30
   localparam int COR_XW     = 34;
   localparam int COR_ZW     = 33;
   localparam int COR_STEPS  = 30;
   localparam int COR_CNT_W  = $clog2(COR_STEPS);
   localparam logic signed [COR_XW-1:0] COR_GAIN = 34'sd652032874;

   // arithmetic constants
   localparam logic [MUL_B_W-1:0] PI_Q30  = 42'd3373259426;
   localparam logic [MUL_B_W-1:0] ARC_K   = 42'd1570796326795;
   localparam logic [MUL_B_W-1:0] RATE_K  = 42'd6283185;
   localparam logic [MUL_B_W-1:0] SPEED_K = 42'd1000000;
   // 2^32 / 6 rounded up; times x then >> 32 gives floor(x / 6) for x below 2^31
   localparam logic [MUL_B_W-1:0] SIXTH_RECIP = 42'd715827883;
   localparam logic [MUL_B_W-1:0] ONE_Q30 = 42'd1073741824;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_DIST_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_SCALE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_MAX  = 2'd2;
   localparam logic [31:0] DIST_SCALE_RST = 32'd8433149;
   localparam logic [30:0] YAW_SCALE_RST  = 31'd33140183;
   localparam logic [30:0] STEER_MAX_RST  = 31'd357913941;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE, ST_ANG, ST_COS, ST_P, ST_DS, ST_DPSI, ST_ARC,
      ST_H1, ST_H2, ST_H3, ST_HL, ST_HC, ST_HD, ST_DSF, ST_MID,
      ST_MX, ST_MY, ST_RQ, ST_RQK, ST_RRK, ST_RRD, ST_RFIN, ST_DONE
   } state_type;

   // arctangent of 2^-i, binary angle with 2^32 a full turn
   function automatic logic [29:0] atan_lut(input logic [COR_CNT_W-1:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2FA;
         5'd15: v = 30'h0000517D;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A30;
         5'd19: v = 30'h00000518;
         5'd20: v = 30'h0000028C;
         5'd21: v = 30'h00000146;
         5'd22: v = 30'h000000A3;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000029;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000003;
         5'd29: v = 30'h00000001;
         default: v = 30'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/wheel_odometry_integrator.sv -----
// Wheel odometry integrator top level: sequencer over a shared serial
// multiplier, divider and CORDIC. Depends on woi_pkg, woi_mul, woi_div, woi_cordic.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | req_tdata: timestamp, steering, four wheel totals
//  rsp     | out | rsp_tvalid/tready   | rsp_tdata: pose x/y, heading, speed, yaw rate;
//          |     |                     | rsp_tuser: zero step time flag
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_wdata (always ready)
//
// The first item after reset is taken and gives no result.
// Every later item runs through the bit-serial multiplier (8 to 15 products),
// the divider (up to 5 quotients) and the CORDIC, which serves each angle.
// req_tready is high only while idle; a finished result waits in the output
// register and the next item is taken while it waits.
// Reset is synchronous and restores the register reset values and the pose.
`default_nettype none

module wheel_odometry_integrator (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: timestamp_us, steering, front_left_total, front_right_total,
   //            rear_left_total, rear_right_total
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [woi_pkg::REQ_W-1:0]           req_tdata,
   // rsp_tdata: pose_x, pose_y, heading, speed, yaw_rate
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [woi_pkg::RSP_W-1:0]           rsp_tdata,
   // rsp_tuser: zero_step_time
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [woi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [woi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PW = woi_pkg::MUL_P_W;

   // configuration
   logic [31:0] dist_scale_ff;
   logic [30:0] yaw_scale_ff, steer_max_ff;

   // sequencer and persistent state
   woi_pkg::state_type state_ff, state_in;
   logic               go_ff, go_in;
   logic               first_ff, first_in;
   logic [31:0]        last_time_ff, last_time_in;
   logic [31:0]        prev_ff [4];
   logic [31:0]        prev_in [4];
   logic [31:0]        pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, head_ff, head_in;
   logic               rsel_ff, rsel_in;

   // per-item working registers
   logic [31:0]        dt_ff, dt_in;
   logic signed [15:0] steer_ff, steer_in;
   logic signed [32:0] nf_ff, nf_in, nr_ff, nr_in, rdiff_ff, rdiff_in;
   logic [31:0]        ang_ff, ang_in;
   logic signed [63:0] p_ff, p_in, ds_ff, ds_in, dpsi_ff, dpsi_in, dsf_ff, dsf_in;
   logic [63:0]        h_ff, h_in, qk_ff, qk_in, t_ff, t_in;
   logic signed [41:0] f_ff, f_in;
   logic [31:0]        spd_ff, spd_in, yr_ff, yr_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [woi_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_zero_ff, rsp_zero_in;

   // shared units
   logic                                 mul_start, mul_done;
   logic signed [woi_pkg::MUL_A_W-1:0]   mul_a;
   logic signed [woi_pkg::MUL_B_W-1:0]   mul_b;
   logic signed [PW-1:0]                 mul_p, mul_sh14, mul_sh30, mul_sh32;
   logic                                 div_start, div_done;
   logic [63:0]                          div_n, div_d, div_q, div_r;
   logic                                 cor_start, cor_done;
   logic [31:0]                          cor_ang;
   logic signed [woi_pkg::COR_XW-1:0]    cor_c, cor_s;

   // helpers
   logic               req_fire, rsp_fire;
   logic [31:0]        tot [4];
   logic [31:0]        delta [4];
   logic [63:0]        mag, rate_m, rate_sum;
   logic [33:0]        am;
   logic               rate_neg;
   logic [31:0]        rate_res;
   logic [41:0]        rate_k;

   woi_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_p)
   );

   woi_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_n), .den (div_d), .done (div_done), .quo (div_q), .rem (div_r)
   );

   woi_cordic u_cordic (
      .clock (clock), .reset (reset), .start (cor_start), .angle (cor_ang),
      .done (cor_done), .cos_q30 (cor_c), .sin_q30 (cor_s)
   );

   // add a signed step to a Q16.16 accumulator with saturation
   function automatic logic [31:0] sat_add(input logic [31:0] acc,
                                           input logic signed [63:0] d);
      logic signed [65:0] v;
      v = 66'(signed'(acc)) + 66'(d);
      if (v > 66'sh7FFF_FFFF) begin
         return 32'h7FFF_FFFF;
      end else if (v < -66'sh8000_0000) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_valid_ff & rsp_tready;
   assign req_tready = (state_ff == woi_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   assign tot[0] = req_tdata[79:48];
   assign tot[1] = req_tdata[111:80];
   assign tot[2] = req_tdata[143:112];
   assign tot[3] = req_tdata[175:144];

   // wrapping per-wheel deltas
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         delta[i] = tot[i] - prev_ff[i];
      end
   end

   assign mul_sh14 = mul_p >>> 14;
   assign mul_sh30 = mul_p >>> 30;
   assign mul_sh32 = mul_p >>> 32;
   assign mag      = dpsi_ff[63] ? 64'(-dpsi_ff) : 64'(dpsi_ff);
   assign am       = cor_s[woi_pkg::COR_XW-1] ? 34'(-cor_s) : 34'(cor_s);
   assign rate_neg = rsel_ff ? dpsi_ff[63] : ds_ff[63];
   assign rate_m   = rsel_ff ? mag : (ds_ff[63] ? 64'(-ds_ff) : 64'(ds_ff));
   assign rate_k   = rsel_ff ? woi_pkg::RATE_K : woi_pkg::SPEED_K;
   assign rate_sum = qk_ff + div_q;

   // signed saturation of the rate magnitude
   always_comb begin
      if (rate_neg) begin
         rate_res = (t_ff >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-t_ff);
      end else begin
         rate_res = (t_ff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : t_ff[31:0];
      end
   end

   // sequencer: next state, unit launches and working registers
   always_comb begin
      state_in     = state_ff;
      go_in        = go_ff;
      first_in     = first_ff;
      last_time_in = last_time_ff;
      prev_in      = prev_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      rsel_in      = rsel_ff;
      dt_in        = dt_ff;
      steer_in     = steer_ff;
      nf_in        = nf_ff;
      nr_in        = nr_ff;
      rdiff_in     = rdiff_ff;
      ang_in       = ang_ff;
      p_in         = p_ff;
      ds_in        = ds_ff;
      dpsi_in      = dpsi_ff;
      dsf_in       = dsf_ff;
      h_in         = h_ff;
      qk_in        = qk_ff;
      t_in         = t_ff;
      f_in         = f_ff;
      spd_in       = spd_ff;
      yr_in        = yr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_zero_in  = rsp_zero_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_n        = '0;
      div_d        = {32'd0, dt_ff};
      cor_start    = 1'b0;
      cor_ang      = ang_ff;

      unique case (state_ff)
         woi_pkg::ST_IDLE: begin
            if (req_fire) begin
               prev_in      = tot;
               last_time_in = req_tdata[31:0];
               if (first_ff) begin
                  first_in = 1'b0;
               end else begin
                  dt_in    = req_tdata[31:0] - last_time_ff;
                  steer_in = req_tdata[47:32];
                  nf_in    = 33'(signed'(delta[0])) + 33'(signed'(delta[1]));
                  nr_in    = 33'(signed'(delta[2])) + 33'(signed'(delta[3]));
                  rdiff_in = 33'(signed'(delta[3])) - 33'(signed'(delta[2]));
                  state_in = woi_pkg::ST_ANG;
               end
            end
         end
         // steering angle in binary units
         woi_pkg::ST_ANG: begin
            mul_a = 65'(steer_ff);
            mul_b = {11'd0, steer_max_ff};
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               ang_in   = mul_p[46:15];
               state_in = woi_pkg::ST_COS;
            end
         end
         woi_pkg::ST_COS: begin
            if (!go_ff) begin
               cor_start = 1'b1;
               go_in     = 1'b1;
            end else if (cor_done) begin
               go_in    = 1'b0;
               state_in = woi_pkg::ST_P;
            end
         end
         // front pulses times cos plus rear pulses, Q16.16
         woi_pkg::ST_P: begin
            mul_a = 65'(nf_ff);
            mul_b = 42'(cor_c);
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               p_in     = mul_sh14[63:0] + {{15{nr_ff[32]}}, nr_ff, 16'd0};
               state_in = woi_pkg::ST_DS;
            end
         end
         woi_pkg::ST_DS: begin
            mul_a = 65'(p_ff);
            mul_b = {10'd0, dist_scale_ff};
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               ds_in    = mul_sh32[63:0];
               state_in = woi_pkg::ST_DPSI;
            end
         end
         // heading change from the rear wheels
         woi_pkg::ST_DPSI: begin
            mul_a = 65'(rdiff_ff);
            mul_b = {11'd0, yaw_scale_ff};
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               dpsi_in  = mul_p[63:0];
               state_in = woi_pkg::ST_ARC;
            end
         end
         // arc versus straight step
         woi_pkg::ST_ARC: begin
            mul_a = {1'b0, mag};
            mul_b = woi_pkg::ARC_K;
            if (mag[63:22] != '0) begin
               state_in = (mag[63:24] != '0) ? woi_pkg::ST_HL : woi_pkg::ST_H1;
            end else if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in = 1'b0;
               if (mul_p[63:0] > {2'd0, dt_ff, 30'd0}) begin
                  state_in = woi_pkg::ST_H1;
               end else begin
                  f_in     = woi_pkg::ONE_Q30;
                  state_in = woi_pkg::ST_DSF;
               end
            end
         end
         // small half angle: chord factor 1 - h^2/6
         woi_pkg::ST_H1: begin
            mul_a = {1'b0, mag};
            mul_b = woi_pkg::PI_Q30;
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               h_in     = mul_sh32[63:0];
               state_in = woi_pkg::ST_H2;
            end
         end
         woi_pkg::ST_H2: begin
            mul_a = {1'b0, h_ff};
            mul_b = h_ff[41:0];
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               h_in     = mul_sh30[63:0];
               state_in = woi_pkg::ST_H3;
            end
         end
         // divide by 6 through the reciprocal
         woi_pkg::ST_H3: begin
            mul_a = {1'b0, h_ff};
            mul_b = woi_pkg::SIXTH_RECIP;
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               f_in     = woi_pkg::ONE_Q30 - mul_sh32[41:0];
               state_in = woi_pkg::ST_DSF;
            end
         end
         // large half angle: chord factor sin(h)/h
         woi_pkg::ST_HL: begin
            mul_a = {1'b0, mag};
            mul_b = woi_pkg::PI_Q30;
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               h_in     = mul_sh32[63:0];
               state_in = woi_pkg::ST_HC;
            end
         end
         woi_pkg::ST_HC: begin
            cor_ang = mag[32:1];
            if (!go_ff) begin
               cor_start = 1'b1;
               go_in     = 1'b1;
            end else if (cor_done) begin
               go_in    = 1'b0;
               state_in = woi_pkg::ST_HD;
            end
         end
         woi_pkg::ST_HD: begin
            div_n = {am, 30'd0};
            div_d = h_ff;
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               f_in     = cor_s[woi_pkg::COR_XW-1] ? -div_q[41:0] : div_q[41:0];
               state_in = woi_pkg::ST_DSF;
            end
         end
         // chord length
         woi_pkg::ST_DSF: begin
            mul_a = 65'(ds_ff);
            mul_b = f_ff;
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               dsf_in   = mul_sh30[63:0];
               state_in = woi_pkg::ST_MID;
            end
         end
         // direction at the mid heading
         woi_pkg::ST_MID: begin
            cor_ang = head_ff + dpsi_ff[32:1];
            if (!go_ff) begin
               cor_start = 1'b1;
               go_in     = 1'b1;
            end else if (cor_done) begin
               go_in    = 1'b0;
               state_in = woi_pkg::ST_MX;
            end
         end
         woi_pkg::ST_MX: begin
            mul_a = 65'(dsf_ff);
            mul_b = 42'(cor_c);
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               pos_x_in = sat_add(pos_x_ff, mul_sh30[63:0]);
               state_in = woi_pkg::ST_MY;
            end
         end
         woi_pkg::ST_MY: begin
            mul_a = 65'(dsf_ff);
            mul_b = 42'(cor_s);
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               pos_y_in = sat_add(pos_y_ff, mul_sh30[63:0]);
               head_in  = head_ff + dpsi_ff[31:0];
               rsel_in  = 1'b0;
               if (dt_ff == '0) begin
                  spd_in   = '0;
                  yr_in    = '0;
                  state_in = woi_pkg::ST_DONE;
               end else begin
                  state_in = woi_pkg::ST_RQ;
               end
            end
         end
         // rate: magnitude over dt, whole part first
         woi_pkg::ST_RQ: begin
            div_n = rate_m;
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in = 1'b0;
               if (rsel_ff ? (div_q[63:25] != '0) : (div_q[63:12] != '0)) begin
                  t_in     = 64'h8000_0000;
                  state_in = woi_pkg::ST_RFIN;
               end else begin
                  state_in = woi_pkg::ST_RQK;
               end
            end
         end
         woi_pkg::ST_RQK: begin
            mul_a = {1'b0, div_q};
            mul_b = rate_k;
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               qk_in    = mul_p[63:0];
               state_in = woi_pkg::ST_RRK;
            end
         end
         woi_pkg::ST_RRK: begin
            mul_a = {1'b0, div_r};
            mul_b = rate_k;
            if (!go_ff) begin
               mul_start = 1'b1;
               go_in     = 1'b1;
            end else if (mul_done) begin
               go_in    = 1'b0;
               state_in = woi_pkg::ST_RRD;
            end
         end
         woi_pkg::ST_RRD: begin
            div_n = mul_p[63:0];
            if (!go_ff) begin
               div_start = 1'b1;
               go_in     = 1'b1;
            end else if (div_done) begin
               go_in    = 1'b0;
               t_in     = rsel_ff ? (rate_sum >> 16) : rate_sum;
               state_in = woi_pkg::ST_RFIN;
            end
         end
         woi_pkg::ST_RFIN: begin
            if (!rsel_ff) begin
               spd_in   = rate_res;
               rsel_in  = 1'b1;
               state_in = woi_pkg::ST_RQ;
            end else begin
               yr_in    = rate_res;
               state_in = woi_pkg::ST_DONE;
            end
         end
         // hand the item to the output register once it is free
         woi_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {yr_ff, spd_ff, head_ff, pos_y_ff, pos_x_ff};
               rsp_zero_in  = (dt_ff == '0);
               state_in     = woi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = woi_pkg::ST_IDLE;
            go_in    = 1'b0;
         end
      endcase
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= woi_pkg::ST_IDLE;
         go_ff         <= 1'b0;
         first_ff      <= 1'b1;
         last_time_ff  <= '0;
         prev_ff       <= '{default: '0};
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         head_ff       <= '0;
         rsel_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dist_scale_ff <= woi_pkg::DIST_SCALE_RST;
         yaw_scale_ff  <= woi_pkg::YAW_SCALE_RST;
         steer_max_ff  <= woi_pkg::STEER_MAX_RST;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         first_ff     <= first_in;
         last_time_ff <= last_time_in;
         prev_ff      <= prev_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         rsel_ff      <= rsel_in;
         rsp_valid_ff <= rsp_valid_in;
         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               woi_pkg::CSR_DIST_SCALE: dist_scale_ff <= csr_wdata;
               woi_pkg::CSR_YAW_SCALE:  yaw_scale_ff  <= csr_wdata[30:0];
               woi_pkg::CSR_STEER_MAX:  steer_max_ff  <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   // working and output payload
   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      steer_ff    <= steer_in;
      nf_ff       <= nf_in;
      nr_ff       <= nr_in;
      rdiff_ff    <= rdiff_in;
      ang_ff      <= ang_in;
      p_ff        <= p_in;
      ds_ff       <= ds_in;
      dpsi_ff     <= dpsi_in;
      dsf_ff      <= dsf_in;
      h_ff        <= h_in;
      qk_ff       <= qk_in;
      t_ff        <= t_in;
      f_ff        <= f_in;
      spd_ff      <= spd_in;
      yr_ff       <= yr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_zero_ff;

endmodule

`default_nettype wire

// ----- hdl/woi_mul.sv -----
// Bit-serial signed multiplier, one bit of b per cycle (shift and add).
// Depends on woi_pkg for operand widths.
`default_nettype none

module woi_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [woi_pkg::MUL_A_W-1:0]   a,
   input  logic signed [woi_pkg::MUL_B_W-1:0]   b,
   output logic                                 done,
   output logic signed [woi_pkg::MUL_P_W-1:0]   prod
);

   localparam int HW = woi_pkg::MUL_A_W + 2;
   localparam logic [woi_pkg::MUL_CNT_W-1:0] LAST = woi_pkg::MUL_CNT_W'(woi_pkg::MUL_B_W - 1);

   logic signed [HW-1:0]                 hi_ff, hi_in, ext, addend, sum;
   logic [woi_pkg::MUL_B_W-1:0]          lo_ff, lo_in;
   logic signed [woi_pkg::MUL_A_W-1:0]   mc_ff, mc_in;
   logic [woi_pkg::MUL_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 busy_ff, busy_in, done_ff, done_in;

   // one partial product a cycle, sign bit of b weighs negative
   always_comb begin
      ext    = HW'(mc_ff);
      addend = '0;
      if (lo_ff[0]) begin
         addend = (cnt_ff == LAST) ? -ext : ext;
      end
      sum     = hi_ff + addend;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mc_in   = mc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         hi_in   = '0;
         lo_in   = b;
         mc_in   = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum >>> 1;
         lo_in  = {sum[0], lo_ff[woi_pkg::MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      mc_ff  <= mc_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff[woi_pkg::MUL_A_W-1:0], lo_ff};

endmodule

`default_nettype wire

// ----- hdl/woi_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on woi_pkg for widths.
`default_nettype none

module woi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [woi_pkg::DIV_W-1:0]     num,
   input  logic [woi_pkg::DIV_W-1:0]     den,
   output logic                          done,
   output logic [woi_pkg::DIV_W-1:0]     quo,
   output logic [woi_pkg::DIV_W-1:0]     rem
);

   localparam int W = woi_pkg::DIV_W;
   localparam logic [woi_pkg::DIV_CNT_W-1:0] LAST = woi_pkg::DIV_CNT_W'(W - 1);

   logic [W:0]                      rem_ff, rem_in, shifted, diff;
   logic [W-1:0]                    quo_ff, quo_in, den_ff, den_in;
   logic [woi_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in, done_ff, done_in;
   logic                            fits;

   // shift in the next dividend bit and try a subtract
   always_comb begin
      shifted = {rem_ff[W-1:0], quo_ff[W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff : shifted;
         quo_in = {quo_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff[W-1:0];

endmodule

`default_nettype wire

// ----- hdl/woi_cordic.sv -----
// Iterative rotation-mode CORDIC giving cos and sin in Q2.30, one step a cycle.
// Depends on woi_pkg for widths, gain and the arctangent table.
`default_nettype none

module woi_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [31:0]                         angle,
   output logic                                done,
   output logic signed [woi_pkg::COR_XW-1:0]   cos_q30,
   output logic signed [woi_pkg::COR_XW-1:0]   sin_q30
);

   localparam int XW = woi_pkg::COR_XW;
   localparam int ZW = woi_pkg::COR_ZW;
   localparam logic [woi_pkg::COR_CNT_W-1:0] LAST =
      woi_pkg::COR_CNT_W'(woi_pkg::COR_STEPS - 1);

   logic signed [XW-1:0]             x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ZW-1:0]             z_ff, z_in, at;
   logic [woi_pkg::COR_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                             flip_ff, flip_in;
   logic                             busy_ff, busy_in, done_ff, done_in;
   logic [31:0]                      quarter, folded;

   always_comb begin
      // fold the back half-plane onto the front one
      quarter = angle + 32'h4000_0000;
      folded  = quarter[31] ? (angle ^ 32'h8000_0000) : angle;
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      at      = ZW'(woi_pkg::atan_lut(cnt_ff));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      flip_in = flip_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = woi_pkg::COR_GAIN;
         y_in    = '0;
         z_in    = ZW'(signed'(folded));
         cnt_in  = '0;
         flip_in = quarter[31];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cnt_ff  <= cnt_in;
      flip_ff <= flip_in;
   end

   assign done    = done_ff;
   assign cos_q30 = flip_ff ? -x_ff : x_ff;
   assign sin_q30 = flip_ff ? -y_ff : y_ff;

endmodule

`default_nettype wire

// ----- hdl/woi_checker.sv -----
// Port-level checks for the wheel odometry integrator, bound to the top level.
// Depends on woi_pkg for payload widths.
`default_nettype none

module woi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [woi_pkg::RSP_W-1:0]     rsp_tdata,
   input logic [0:0]                    rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   // a zero step time gives zero speed and yaw rate
   a_zero_rates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[127:96] == 32'd0 && rsp_tdata[159:128] == 32'd0)
      else $error("nonzero rate with zero step time");

endmodule

bind wheel_odometry_integrator woi_checker u_woi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
